[hdl/frame_store_circle_mirror_copy_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the frame store unit
// Shorthand for the clocked, reset-qualified checks in the top level.
// ----------------------------------------------------------------------------
`ifndef FRAME_STORE_CIRCLE_MIRROR_COPY_UNIT_MACROS_SVH
`define FRAME_STORE_CIRCLE_MIRROR_COPY_UNIT_MACROS_SVH

// consequent must hold in the same cycle
`define CMF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the next cycle
`define CMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/cmf_pkg.sv]
// ----------------------------------------------------------------------------
// cmf_pkg
// Shared types and codes of the frame store unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cmf_pkg;

    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_CIRCLE = 3'd2;
    localparam logic [2:0] CMD_MIRROR = 3'd3;
    localparam logic [2:0] CMD_COPY   = 3'd4;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ,
        OP_CIRCLE,
        OP_MIRROR,
        OP_COPY
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_RD_WAIT,
        ST_CIRCLE,
        ST_M_RDP,
        ST_M_RDQ,
        ST_M_WRP,
        ST_M_WRQ,
        ST_C_RD,
        ST_C_WR,
        ST_C_RD2,
        ST_C_WR2,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  x_start;
        logic [7:0]  y_start;
        logic [8:0]  x_end;
        logic [8:0]  y_end;
        logic [7:0]  dest_x;
        logic [7:0]  dest_y;
        logic [7:0]  radius;
        logic [7:0]  ring_width;
        logic [23:0] colour_a;
        logic [23:0] colour_b;
        logic        flag;
    } t_item;

    typedef struct packed {
        logic [23:0] pixel_value;
        logic        fault;
    } t_result;

    typedef struct packed {
        logic [8:0] w;
        logic [8:0] h;
    } t_geom;

    typedef struct packed {
        t_op   op;
        logic  fault;
        t_item item;
    } t_job;

endpackage

[hdl/cmf_front.sv]
// ----------------------------------------------------------------------------
// cmf_front
// Checks an incoming command against the frame and turns it into a job.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmf_front (
    input  cmf_pkg::t_item i_item,
    input  cmf_pkg::t_geom i_geom,
    output cmf_pkg::t_job  o_job
);
    import cmf_pkg::*;

    logic in_frame;
    logic box_ok;

    always_comb begin
        in_frame = ({1'b0, i_item.x_start} < i_geom.w) && ({1'b0, i_item.y_start} < i_geom.h);
        box_ok = ({1'b0, i_item.x_start} <= i_item.x_end)
              && ({1'b0, i_item.y_start} <= i_item.y_end)
              && (i_item.x_end <= i_geom.w) && (i_item.y_end <= i_geom.h);
    end

    always_comb begin
        o_job.item  = i_item;
        o_job.op    = OP_NONE;
        o_job.fault = 1'b1;
        unique case (i_item.cmd)
            CMD_WRITE: begin
                if (in_frame) begin
                    o_job.op    = OP_WRITE;
                    o_job.fault = 1'b0;
                end
            end
            CMD_READ: begin
                if (in_frame) begin
                    o_job.op    = OP_READ;
                    o_job.fault = 1'b0;
                end
            end
            CMD_CIRCLE: begin
                if (in_frame) begin
                    o_job.op    = OP_CIRCLE;
                    o_job.fault = 1'b0;
                end
            end
            CMD_MIRROR: begin
                if (box_ok) begin
                    o_job.op    = OP_MIRROR;
                    o_job.fault = 1'b0;
                end
            end
            CMD_COPY: begin
                if (box_ok) begin
                    o_job.op    = OP_COPY;
                    o_job.fault = 1'b0;
                end
            end
            default: begin
                o_job.op    = OP_NONE;
                o_job.fault = 1'b1;
            end
        endcase
    end

endmodule

[hdl/cmf_queue.sv]
// ----------------------------------------------------------------------------
// cmf_queue
// Short job queue between the command front and the pixel engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cmf_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output cmf_pkg::t_job o_data,
    output logic          o_empty
);
    import cmf_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job            r_mem [QUEUE_DEPTH];
    logic [IW-1:0]   r_wr, n_wr;
    logic [IW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            do_push;
    logic            do_pop;

    always_comb begin
        o_full  = (r_cnt == CW'(QUEUE_DEPTH));
        o_empty = (r_cnt == '0);
        do_push = i_push && !o_full;
        do_pop  = i_pop && !o_empty;
        o_data  = r_mem[r_rd];
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_cnt   = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == IW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == IW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

[hdl/cmf_engine.sv]
// ----------------------------------------------------------------------------
// cmf_engine
// Runs one job at a time over the frame memory and holds its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cmf_engine #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cmf_pkg::t_geom   i_geom,
    input  cmf_pkg::t_job    i_job,
    input  logic             i_job_valid,
    output logic             o_job_pop,
    input  logic             i_res_pop,
    output cmf_pkg::t_result o_res,
    output logic             o_res_valid
);
    import cmf_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    logic [23:0]   r_frame   [DEPTH];
    logic [23:0]   r_scratch [DEPTH];

    t_state        r_state, n_state;
    t_job          r_job;
    logic [8:0]    r_u, r_v;
    logic [15:0]   r_outer, r_inner;
    logic [23:0]   r_frd, r_srd, r_hold;
    t_result       r_res;
    logic          r_res_valid;

    logic [8:0]    ulim, vlim;
    logic [8:0]    xs, ys;
    logic [8:0]    p_x, p_y, q_x, q_y;
    logic [9:0]    d_x, d_y;
    logic [8:0]    adx, ady;
    logic [17:0]   sqx, sqy;
    logic [18:0]   dist_sq;
    logic [7:0]    inner_r;
    logic          last_u, last_v, step;
    logic          f_we, s_we;
    logic [AW-1:0] f_addr, s_addr;
    logic [23:0]   f_wd;

    function automatic logic [AW-1:0] addr_of(input logic [9:0] x, input logic [9:0] y);
        return AW'(y) * AW'(MAX_WIDTH) + AW'(x);
    endfunction

    // loop bounds and coordinates of the current pixel or pixel pair
    always_comb begin
        xs = {1'b0, r_job.item.x_start};
        ys = {1'b0, r_job.item.y_start};
        unique case (r_job.op)
            OP_CIRCLE: begin
                ulim = i_geom.w;
                vlim = i_geom.h;
            end
            OP_MIRROR: begin
                if (r_job.item.flag) begin
                    ulim = (r_job.item.x_end - xs) >> 1;
                    vlim = r_job.item.y_end - ys;
                end else begin
                    ulim = r_job.item.x_end - xs;
                    vlim = (r_job.item.y_end - ys) >> 1;
                end
            end
            OP_COPY: begin
                ulim = r_job.item.x_end - xs;
                vlim = r_job.item.y_end - ys;
            end
            default: begin
                ulim = '0;
                vlim = '0;
            end
        endcase
        if (r_job.op == OP_CIRCLE) begin
            p_x = r_u;
            p_y = r_v;
        end else begin
            p_x = xs + r_u;
            p_y = ys + r_v;
        end
        if (r_job.item.flag) begin
            q_x = r_job.item.x_end - 9'd1 - r_u;
            q_y = p_y;
        end else begin
            q_x = p_x;
            q_y = r_job.item.y_end - 9'd1 - r_v;
        end
        d_x = {2'b0, r_job.item.dest_x} + {1'b0, r_u};
        d_y = {2'b0, r_job.item.dest_y} + {1'b0, r_v};
        adx = (r_u >= xs) ? r_u - xs : xs - r_u;
        ady = (r_v >= ys) ? r_v - ys : ys - r_v;
        sqx = {9'd0, adx} * {9'd0, adx};
        sqy = {9'd0, ady} * {9'd0, ady};
        dist_sq = {1'b0, sqx} + {1'b0, sqy};
        inner_r = (r_job.item.ring_width > r_job.item.radius)
                ? 8'd0 : r_job.item.radius - r_job.item.ring_width;
        last_u = ({1'b0, r_u} + 10'd1 == {1'b0, ulim});
        last_v = ({1'b0, r_v} + 10'd1 == {1'b0, vlim});
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid && !r_res_valid) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                unique case (r_job.op)
                    OP_READ:   n_state = ST_RD_WAIT;
                    OP_CIRCLE: n_state = ST_CIRCLE;
                    OP_MIRROR: n_state = (ulim == '0 || vlim == '0) ? ST_DONE : ST_M_RDP;
                    OP_COPY:   n_state = (ulim == '0 || vlim == '0) ? ST_DONE : ST_C_RD;
                    default:   n_state = ST_DONE;
                endcase
            end
            ST_RD_WAIT: n_state = ST_DONE;
            ST_CIRCLE:  n_state = (last_u && last_v) ? ST_DONE : ST_CIRCLE;
            ST_M_RDP:   n_state = ST_M_RDQ;
            ST_M_RDQ:   n_state = ST_M_WRP;
            ST_M_WRP:   n_state = ST_M_WRQ;
            ST_M_WRQ:   n_state = (last_u && last_v) ? ST_DONE : ST_M_RDP;
            ST_C_RD:    n_state = ST_C_WR;
            ST_C_WR:    n_state = (last_u && last_v) ? ST_C_RD2 : ST_C_RD;
            ST_C_RD2:   n_state = ST_C_WR2;
            ST_C_WR2:   n_state = (last_u && last_v) ? ST_DONE : ST_C_RD2;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // memory ports and loop stepping
    always_comb begin
        o_job_pop = (r_state == ST_IDLE) && i_job_valid && !r_res_valid;
        f_we   = 1'b0;
        f_addr = addr_of({1'b0, p_x}, {1'b0, p_y});
        f_wd   = r_job.item.colour_a;
        s_we   = 1'b0;
        s_addr = addr_of({1'b0, r_u}, {1'b0, r_v});
        step   = 1'b0;
        unique case (r_state)
            ST_START: begin
                f_we = (r_job.op == OP_WRITE);
            end
            ST_CIRCLE: begin
                step = 1'b1;
                if (dist_sq < {3'b0, r_outer}) begin
                    if (dist_sq < {3'b0, r_inner}) begin
                        f_we = r_job.item.flag;
                        f_wd = r_job.item.colour_b;
                    end else begin
                        f_we = 1'b1;
                    end
                end
            end
            ST_M_RDQ: begin
                f_addr = addr_of({1'b0, q_x}, {1'b0, q_y});
            end
            ST_M_WRP: begin
                f_we = 1'b1;
                f_wd = r_frd;
            end
            ST_M_WRQ: begin
                f_we   = 1'b1;
                f_addr = addr_of({1'b0, q_x}, {1'b0, q_y});
                f_wd   = r_hold;
                step   = 1'b1;
            end
            ST_C_WR: begin
                s_we = 1'b1;
                step = 1'b1;
            end
            ST_C_WR2: begin
                f_we   = (d_x < {1'b0, i_geom.w}) && (d_y < {1'b0, i_geom.h});
                f_addr = addr_of(d_x, d_y);
                f_wd   = r_srd;
                step   = 1'b1;
            end
            default: begin
                f_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_frame[f_addr] <= f_wd;
        end
        r_frd <= r_frame[f_addr];
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_scratch[s_addr] <= r_frd;
        end
        r_srd <= r_scratch[s_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            priority if (r_state == ST_DONE) begin
                r_res_valid <= 1'b1;
            end else if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job <= i_job;
            r_u   <= '0;
            r_v   <= '0;
        end else if (step) begin
            if (last_u) begin
                r_u <= '0;
                r_v <= last_v ? '0 : r_v + 9'd1;
            end else begin
                r_u <= r_u + 9'd1;
            end
        end
        if (r_state == ST_START) begin
            r_outer <= r_job.item.radius * r_job.item.radius;
            r_inner <= inner_r * inner_r;
        end
        if (r_state == ST_M_RDQ) begin
            r_hold <= r_frd;
        end
        if (r_state == ST_DONE) begin
            r_res.fault       <= r_job.fault;
            r_res.pixel_value <= (r_job.op == OP_READ) ? r_frd : 24'd0;
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

endmodule

[hdl/frame_store_circle_mirror_copy_unit.sv]
// ----------------------------------------------------------------------------
// frame_store_circle_mirror_copy_unit
// Pixel frame store with write, read, circle, mirror and copy commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "frame_store_circle_mirror_copy_unit_macros.svh"

// A frame of up to MAX_WIDTH by MAX_HEIGHT 24-bit pixels sits in a single-port
// memory, and every command beat pushed in returns exactly one result beat, in
// order. Commands are checked on entry and parked in a two-deep job queue, so
// the input side keeps taking beats while the engine works and while a result
// waits to be popped, until the queue is full. The engine runs one job at a
// time and its speed is set by the one frame memory port: circle steps over
// the whole frame, one pixel a cycle; mirror reads both pixels of each swapped
// pair, then writes both; copy first fills a scratch copy of the source box,
// then writes it back. The memories are not cleared after reset; reading a
// pixel never written returns junk. Frame width and height are written on
// the configuration channel; the user must write them only while the block is
// idle, which the block itself does not enforce. They reset to 256 and are
// clamped to 1..MAX.

module frame_store_circle_mirror_copy_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  cmf_pkg::t_item   i_item,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output cmf_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [8:0]       i_cfg_data
);
    import cmf_pkg::*;

    logic [8:0] r_frame_width;
    logic [8:0] r_frame_height;
    t_geom      geom;
    t_job       front_job;
    t_job       q_job;
    logic       q_empty;
    logic       job_pop;
    logic       res_valid;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 9'd256;
            r_frame_height <= 9'd256;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_FRAME_WIDTH) begin
                r_frame_width <= i_cfg_data;
            end
            if (i_cfg_index == REG_FRAME_HEIGHT) begin
                r_frame_height <= i_cfg_data;
            end
        end
    end

    // frame size in use: registers clamped into 1..MAX
    always_comb begin
        if (r_frame_width == '0) begin
            geom.w = 9'd1;
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            geom.w = 9'(MAX_WIDTH);
        end else begin
            geom.w = r_frame_width;
        end
        if (r_frame_height == '0) begin
            geom.h = 9'd1;
        end else if (int'(r_frame_height) > MAX_HEIGHT) begin
            geom.h = 9'(MAX_HEIGHT);
        end else begin
            geom.h = r_frame_height;
        end
    end

    cmf_front u_front (
        .i_item (i_item),
        .i_geom (geom),
        .o_job  (front_job)
    );

    cmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (q_job),
        .o_empty (q_empty)
    );

    cmf_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_job       (q_job),
        .i_job_valid (!q_empty),
        .o_job_pop   (job_pop),
        .i_res_pop   (pop),
        .o_res       (o_result),
        .o_res_valid (res_valid)
    );

    assign empty = !res_valid;

    // engine only starts a job with the result slot free
    `CMF_ASSERT_SAME(a_start_slot_free, i_clk, i_rst_n, job_pop, empty, "job started with result pending")
    // only reads carry a pixel value, faulted beats are zero
    `CMF_ASSERT_SAME(a_fault_zero, i_clk, i_rst_n, !empty && o_result.fault, o_result.pixel_value == 24'd0, "faulted result carries a value")
    // an accepted beat lands in the job queue
    `CMF_ASSERT_NEXT(a_push_lands, i_clk, i_rst_n, push && !full, !q_empty, "accepted beat lost")

endmodule

[verif/frame_store_circle_mirror_copy_unit_tb.sv]
// ----------------------------------------------------------------------------
// frame_store_circle_mirror_copy_unit_tb
// Self-checking bench for the frame store unit. A scoreboard class keeps its
// own copy of the frame and the frame size, predicts one result beat per
// command beat and checks every popped result in order. A full-frame circle
// first writes every pixel so no later read touches an unwritten entry.
// Directed commands come next, then random traffic over several frame sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_store_circle_mirror_copy_unit_tb;

    import cmf_pkg::*;

    localparam int STORE_DEPTH = 65536;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int LONG_HOLD   = 300;

    // ------------------------------------------------------------------------
    // Frame scoreboard: shadow frame, frame size and expected result beats
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        logic [23:0] pixels [STORE_DEPTH];
        logic [23:0] scratch [STORE_DEPTH];
        int          reg_w;
        int          reg_h;
        t_result     expected_results [$];
        int          errors;

        function new();
            reg_w  = 256;
            reg_h  = 256;
            errors = 0;
        endfunction

        function int used_w();
            return (reg_w < 1) ? 1 : (reg_w > 256) ? 256 : reg_w;
        endfunction

        function int used_h();
            return (reg_h < 1) ? 1 : (reg_h > 256) ? 256 : reg_h;
        endfunction

        function int addr(int x, int y);
            return (y * 256 + x) % STORE_DEPTH;
        endfunction

        function void write_reg(logic [1:0] idx, logic [8:0] val);
            if (idx == REG_FRAME_WIDTH)
                reg_w = int'(val);
            else if (idx == REG_FRAME_HEIGHT)
                reg_h = int'(val);
        endfunction

        function void swap_px(int p, int q);
            logic [23:0] t;
            t         = pixels[p];
            pixels[p] = pixels[q];
            pixels[q] = t;
        endfunction

        // Predict the result of one accepted command and update the frame.
        function void note_command(t_item it);
            int      w, h, xs, ys, xe, ye, i, j, dx, dy, d, outer, inner, ir, bw, bh;
            bit      in_frame, box_good;
            t_result res;
            w        = used_w();
            h        = used_h();
            xs       = int'(it.x_start);
            ys       = int'(it.y_start);
            xe       = int'(it.x_end);
            ye       = int'(it.y_end);
            in_frame = (xs < w) && (ys < h);
            box_good = (xs <= xe) && (ys <= ye) && (xe <= w) && (ye <= h);
            res      = '0;
            case (it.cmd)
                CMD_WRITE: begin
                    if (in_frame) pixels[addr(xs, ys)] = it.colour_a;
                    else res.fault = 1'b1;
                end
                CMD_READ: begin
                    if (in_frame) res.pixel_value = pixels[addr(xs, ys)];
                    else res.fault = 1'b1;
                end
                CMD_CIRCLE: begin
                    if (in_frame) begin
                        outer = int'(it.radius) * int'(it.radius);
                        ir    = (it.ring_width > it.radius) ? 0 :
                                int'(it.radius) - int'(it.ring_width);
                        inner = ir * ir;
                        for (j = 0; j < h; j++) begin
                            for (i = 0; i < w; i++) begin
                                dx = i - xs;
                                dy = j - ys;
                                d  = dx * dx + dy * dy;
                                if (d < outer) begin
                                    if (d >= inner)
                                        pixels[addr(i, j)] = it.colour_a;
                                    else if (it.flag)
                                        pixels[addr(i, j)] = it.colour_b;
                                end
                            end
                        end
                    end else begin
                        res.fault = 1'b1;
                    end
                end
                CMD_MIRROR: begin
                    if (!box_good) begin
                        res.fault = 1'b1;
                    end else if (it.flag) begin
                        for (j = ys; j < ye; j++)
                            for (i = 0; i < (xe - xs) / 2; i++)
                                swap_px(addr(xs + i, j), addr(xe - 1 - i, j));
                    end else begin
                        for (j = 0; j < (ye - ys) / 2; j++)
                            for (i = xs; i < xe; i++)
                                swap_px(addr(i, ys + j), addr(i, ye - 1 - j));
                    end
                end
                CMD_COPY: begin
                    if (box_good) begin
                        bw = xe - xs;
                        bh = ye - ys;
                        for (j = 0; j < bh; j++)
                            for (i = 0; i < bw; i++)
                                scratch[addr(i, j)] = pixels[addr(xs + i, ys + j)];
                        for (j = 0; j < bh && int'(it.dest_y) + j < h; j++)
                            for (i = 0; i < bw && int'(it.dest_x) + i < w; i++)
                                pixels[addr(int'(it.dest_x) + i, int'(it.dest_y) + j)] =
                                    scratch[addr(i, j)];
                    end else begin
                        res.fault = 1'b1;
                    end
                end
                default: res.fault = 1'b1;
            endcase
            expected_results.push_back(res);
        endfunction

        function void check_result(t_result got);
            t_result exp_res;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual %h/%b",
                         $time, got.pixel_value, got.fault);
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            if (got.pixel_value !== exp_res.pixel_value) begin
                $display("%0t: pixel_value mismatch: expected %h, actual %h",
                         $time, exp_res.pixel_value, got.pixel_value);
                errors++;
            end
            if (got.fault !== exp_res.fault) begin
                $display("%0t: fault mismatch: expected %b, actual %b",
                         $time, exp_res.fault, got.fault);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    t_item      i_item = '0;
    logic       full;
    logic       empty;
    logic       pop = 1'b0;
    t_result    o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [8:0] i_cfg_data = '0;

    frame_scoreboard sb = new();
    int              cycles = 0;
    bit              hold_req = 1'b0;   // ask the receiver for one long hold-off
    bit              rx_enable = 1'b0;

    always #5 i_clk = ~i_clk;

    frame_store_circle_mirror_copy_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Watchdog: the slowest legal run is far below this.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("frame_store_circle_mirror_copy_unit_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: check at the rising edge, change pop at the falling edge.
    // Stall pattern changes every segment: always pop, coin flip, or sparse.
    // A hold request from the sender side gives one long stretch of no pops.
    // ------------------------------------------------------------------------
    initial begin
        int seg_left;
        int mode;
        int hold_left;
        seg_left  = 0;
        mode      = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (pop && !empty)
                sb.check_result(o_result);
            @(negedge i_clk);
            if (hold_req && hold_left == 0) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 60);
                mode     = $urandom_range(0, 2);
            end
            seg_left--;
            if (!rx_enable) begin
                pop <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= ($urandom_range(0, 1) == 1);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side tasks
    // ------------------------------------------------------------------------

    // Offer one command beat; push stays high after acceptance so back to
    // back beats keep it asserted without a dip.
    task automatic send_cmd(t_item it);
        @(negedge i_clk);
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_command(it);
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
    endtask

    // Wait until every predicted result beat has been popped.
    task automatic drain();
        idle_cycles(1);
        while (sb.expected_results.size() != 0)
            @(negedge i_clk);
        idle_cycles(8);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [8:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(logic [8:0] w, logic [8:0] h);
        cfg_write(REG_FRAME_WIDTH, w);
        cfg_write(REG_FRAME_HEIGHT, h);
    endtask

    function automatic t_item mk(logic [2:0] cmd, int xs, int ys, int xe, int ye);
        t_item it;
        it          = '0;
        it.cmd      = cmd;
        it.x_start  = 8'(xs);
        it.y_start  = 8'(ys);
        it.x_end    = 9'(xe);
        it.y_end    = 9'(ye);
        it.colour_a = 24'($urandom_range(0, 24'hFFFFFF));
        it.colour_b = 24'($urandom_range(0, 24'hFFFFFF));
        return it;
    endfunction

    function automatic t_item mk_circle(int cx, int cy, int r, int rw, bit fill);
        t_item it;
        it            = mk(CMD_CIRCLE, cx, cy, 0, 0);
        it.radius     = 8'(r);
        it.ring_width = 8'(rw);
        it.flag       = fill;
        return it;
    endfunction

    // Random command shaped by the current frame size: mostly legal
    // coordinates and boxes, some out-of-frame noise and unknown opcodes.
    function automatic t_item rand_cmd(int w, int h);
        t_item it;
        int    pick;
        it      = '0;
        pick    = $urandom_range(0, 99);
        it.cmd  = (pick < 25) ? CMD_WRITE : (pick < 45) ? CMD_READ :
                  (pick < 58) ? CMD_CIRCLE : (pick < 76) ? CMD_MIRROR :
                  (pick < 95) ? CMD_COPY : 3'($urandom_range(5, 7));
        if ($urandom_range(0, 99) < 85) begin
            it.x_start = 8'($urandom_range(0, w - 1));
            it.y_start = 8'($urandom_range(0, h - 1));
            it.x_end   = 9'($urandom_range(it.x_start, w));
            it.y_end   = 9'($urandom_range(it.y_start, h));
        end else begin
            it.x_start = 8'($urandom_range(0, 255));
            it.y_start = 8'($urandom_range(0, 255));
            it.x_end   = 9'($urandom_range(0, 256));
            it.y_end   = 9'($urandom_range(0, 256));
        end
        it.dest_x     = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, w - 1));
        it.dest_y     = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, h - 1));
        it.radius     = 8'(($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 20));
        it.ring_width = 8'(($urandom_range(0, 9) == 0) ? 255
                                                       : $urandom_range(0, it.radius + 2));
        it.colour_a   = 24'($urandom_range(0, 24'hFFFFFF));
        it.colour_b   = 24'($urandom_range(0, 24'hFFFFFF));
        it.flag       = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // One random phase: bursts of beats with gaps, optionally a gap-free run.
    task automatic random_phase(int n, bit gaps);
        int left;
        int burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && left > 0) begin
                send_cmd(rand_cmd(sb.used_w(), sb.used_h()));
                burst--;
                left--;
            end
            if (gaps)
                idle_cycles($urandom_range(0, 6));
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        t_item it;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n   <= 1'b1;
        rx_enable = 1'b1;

        // Full-frame fill: every pixel of the 256x256 store is written once
        send_cmd(mk_circle(128, 128, 255, 0, 1'b1));

        // Directed, full frame: corner pixels, small boxes at the far edges
        it = mk(CMD_WRITE, 0, 0, 0, 0);
        it.colour_a = 24'h000000;
        send_cmd(it);
        it = mk(CMD_WRITE, 255, 255, 0, 0);
        it.colour_a = 24'hFFFFFF;
        send_cmd(it);
        send_cmd(mk(CMD_READ, 0, 0, 0, 0));
        send_cmd(mk(CMD_READ, 255, 255, 0, 0));
        it = mk(CMD_MIRROR, 250, 0, 256, 3);
        it.flag = 1'b1;
        send_cmd(it);                                  // left-right at right edge
        send_cmd(mk(CMD_MIRROR, 0, 252, 4, 256));      // top-bottom at bottom edge
        it = mk(CMD_COPY, 0, 0, 4, 4);
        it.dest_x = 8'd254;
        it.dest_y = 8'd254;
        send_cmd(it);                                  // destination clipped
        send_cmd(mk(CMD_COPY, 10, 0, 5, 2));           // reversed box
        send_cmd(mk(CMD_MIRROR, 5, 5, 5, 9));          // empty box
        send_cmd(mk(3'd5, 0, 0, 0, 0));
        send_cmd(mk(3'd6, 0, 0, 0, 0));
        send_cmd(mk(3'd7, 0, 0, 0, 0));
        send_cmd(mk(CMD_READ, 251, 1, 0, 0));
        drain();

        // Directed, small frame: faults and circle corner cases
        set_frame(9'd8, 9'd6);
        send_cmd(mk(CMD_WRITE, 8, 0, 0, 0));           // column outside
        send_cmd(mk(CMD_READ, 0, 6, 0, 0));            // row outside
        send_cmd(mk(CMD_READ, 7, 5, 0, 0));
        send_cmd(mk_circle(9, 2, 3, 0, 1'b1));         // centre outside
        send_cmd(mk_circle(0, 0, 5, 2, 1'b1));         // partly outside
        send_cmd(mk_circle(4, 3, 3, 9, 1'b0));         // ring wider than radius
        send_cmd(mk_circle(4, 3, 0, 0, 1'b1));         // radius zero
        send_cmd(mk_circle(3, 3, 4, 1, 1'b0));         // ring only, interior kept
        send_cmd(mk(CMD_MIRROR, 0, 0, 9, 2));          // box beyond frame
        it = mk(CMD_COPY, 0, 0, 3, 3);
        it.dest_x = 8'd6;
        it.dest_y = 8'd4;
        send_cmd(it);
        send_cmd(mk(CMD_READ, 7, 5, 0, 0));
        drain();

        // Random phases across frame sizes, register extremes included.
        // The first one also gets a long receiver hold-off so the block
        // fills and pushes back on the input.
        set_frame(9'd5, 9'd7);
        hold_req = 1'b1;
        random_phase(12, 1'b0);
        set_frame(9'd0, 9'd3);                         // width clamps to 1
        random_phase(10, 1'b1);
        set_frame(9'd12, 9'd16);
        random_phase(12, 1'b1);
        set_frame(9'd511, 9'd2);                       // width clamps to 256
        random_phase(12, 1'b1);
        set_frame(9'd3, 9'd511);                       // height clamps to 256
        random_phase(10, 1'b0);
        set_frame(9'd1, 9'd256);
        random_phase(6, 1'b1);
        set_frame(9'd20, 9'd20);
        random_phase(12, 1'b1);

        idle_cycles(20);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("frame_store_circle_mirror_copy_unit_tb: clean");
        end else begin
            $display("frame_store_circle_mirror_copy_unit_tb: errors");
        end
        $finish;
    end

endmodule

[frame_store_circle_mirror_copy_unit.f]
+incdir+hdl
hdl/cmf_pkg.sv
hdl/cmf_front.sv
hdl/cmf_queue.sv
hdl/cmf_engine.sv
hdl/frame_store_circle_mirror_copy_unit.sv
verif/frame_store_circle_mirror_copy_unit_tb.sv
